>>> hw/rtl/gtg_pkg.sv
`default_nettype none

package gtg_pkg;

    // Field widths
    localparam int POS_W = 16;             // Q4.12 positions, speeds, gain
    localparam int HD_W  = 15;             // Q3.12 signed angles
    localparam int IDX_W = 2;              // configuration index

    // CORDIC datapath: Q.20 vector, Q.24 angle accumulator
    localparam int XW     = 28;
    localparam int ZW     = 28;
    localparam int ATAN_N = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // Post-processing widths
    localparam int DIST_W = 17;
    localparam int MAG_W  = 17;

    localparam logic [23:0]          KINV_Q24  = 24'd10188014;
    localparam logic signed [ZW-1:0] PI_Q24    = 28'sd52707179;
    localparam logic [POS_W-1:0]     GOAL_MAX  = 16'd49151;
    localparam logic [DIST_W-1:0]    DIST_MIN  = 17'd409;
    localparam logic [MAG_W-1:0]     ANGLE_MIN = 17'd819;

    // round(atan(2^-i) * 2^24)
    localparam logic [23:0] ATAN_TBL [ATAN_N] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214,  24'd524117,  24'd262123,  24'd131069,
        24'd65536,    24'd32768,   24'd16384,   24'd8192,
        24'd4096,     24'd2048,    24'd1024,    24'd512,
        24'd256,      24'd128,     24'd64,      24'd32,
        24'd16,       24'd8,       24'd4,       24'd2
    };

    typedef enum logic [IDX_W-1:0] {
        CFG_GOAL_X      = 2'd0,
        CFG_GOAL_Y      = 2'd1,
        CFG_GAIN        = 2'd2,
        CFG_SPEED_LIMIT = 2'd3
    } t_cfg_idx;

    // Vector, angle accumulator and the heading that rides along
    typedef struct packed {
        logic signed [XW-1:0]   x;
        logic signed [XW-1:0]   y;
        logic signed [ZW-1:0]   z;
        logic signed [HD_W-1:0] h;
    } t_vec;

endpackage

`default_nettype wire

>>> hw/rtl/gtg_prep.sv
`default_nettype none

module gtg_prep import gtg_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [POS_W-1:0]        i_pos_x,
    input  wire logic [POS_W-1:0]        i_pos_y,
    input  wire logic signed [HD_W-1:0]  i_heading,
    input  wire logic [POS_W-1:0]        i_goal_x,
    input  wire logic [POS_W-1:0]        i_goal_y,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output t_vec                         o_vec
);

    logic signed [POS_W:0]  dx;
    logic signed [POS_W:0]  dy;
    logic signed [XW-1:0]   sx;
    logic signed [XW-1:0]   sy;
    t_vec                   n_vec;
    t_vec                   r_vec;
    logic                   r_valid;

    assign dx = $signed({1'b0, i_goal_x}) - $signed({1'b0, i_pos_x});
    assign dy = $signed({1'b0, i_goal_y}) - $signed({1'b0, i_pos_y});
    // scale to Q.20
    assign sx = {{(XW-POS_W-9){dx[POS_W]}}, dx, 8'd0};
    assign sy = {{(XW-POS_W-9){dy[POS_W]}}, dy, 8'd0};

    // left half plane: mirror the vector, start the angle at +/-pi
    always_comb begin
        n_vec.h = i_heading;
        if (dx[POS_W]) begin
            n_vec.x = -sx;
            n_vec.y = -sy;
            n_vec.z = dy[POS_W] ? -PI_Q24 : PI_Q24;
        end else begin
            n_vec.x = sx;
            n_vec.y = sy;
            n_vec.z = '0;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

>>> hw/rtl/gtg_cell.sv
`default_nettype none

module gtg_cell import gtg_pkg::*; #(
    parameter int STAGE = 0
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_vec i_vec,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_vec      o_vec
);

    localparam logic signed [ZW-1:0] ATAN = $signed({{(ZW-24){1'b0}}, ATAN_TBL[STAGE]});

    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 y_pos;
    t_vec                 n_vec;
    t_vec                 r_vec;
    logic                 r_valid;

    assign x     = i_vec.x;
    assign y     = i_vec.y;
    assign z     = i_vec.z;
    assign xs    = x >>> STAGE;
    assign ys    = y >>> STAGE;
    assign y_pos = !y[XW-1] && (y != '0);

    // one micro-rotation toward y = 0
    always_comb begin
        n_vec.h = i_vec.h;
        if (y_pos) begin
            n_vec.x = x + ys;
            n_vec.y = y - xs;
            n_vec.z = z + ATAN;
        end else begin
            n_vec.x = x - ys;
            n_vec.y = y + xs;
            n_vec.z = z - ATAN;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vec <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;

endmodule

`default_nettype wire

>>> hw/rtl/gtg_post.sv
`default_nettype none

module gtg_post import gtg_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire t_vec              i_vec,
    input  wire logic [POS_W-1:0]  i_gain,
    input  wire logic [POS_W-1:0]  i_speed_limit,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [POS_W-1:0]       o_linear_speed,
    output logic [HD_W-1:0]        o_angular_speed,
    output logic [1:0]             o_stg_valid
);

    // stage A: gain-corrected length, heading error
    logic [25:0]            xu;
    logic [49:0]            prod;
    logic [49:0]            rnd;
    logic signed [ZW-1:0]   zr;
    logic signed [15:0]     bearing;
    logic signed [MAG_W-1:0] angle;
    logic [MAG_W-1:0]       mag;
    logic                   a_ready;
    logic                   r_a_valid;
    logic [DIST_W-1:0]      r_dist;
    logic [MAG_W-1:0]       r_mag;

    // stage B: command select and speed limit
    logic [POS_W+DIST_W-1:0] prod2;
    logic [20:0]             lin_full;
    logic [POS_W-1:0]        lin_sat;
    logic [POS_W-1:0]        n_lin;
    logic [HD_W-1:0]         n_ang;
    logic                    b_ready;
    logic                    r_b_valid;
    logic [POS_W-1:0]        r_lin;
    logic [HD_W-1:0]         r_ang;

    assign xu      = i_vec.x[25:0];
    assign prod    = 50'(xu) * 50'(KINV_Q24);
    assign rnd     = prod + 50'h0_8000_0000;
    assign zr      = i_vec.z + ZW'(2048);
    assign bearing = zr[ZW-1:12];
    assign angle   = {bearing[15], bearing} - {{(MAG_W-HD_W){i_vec.h[HD_W-1]}}, i_vec.h};
    assign mag     = angle[MAG_W-1] ? MAG_W'(-angle) : MAG_W'(angle);

    assign b_ready = !r_b_valid || !i_stall;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_dist <= rnd[48:32];
            r_mag  <= mag;
        end
    end

    assign prod2    = 33'(i_gain) * 33'(r_dist);
    assign lin_full = prod2[32:12];
    assign lin_sat  = (lin_full > 21'(i_speed_limit)) ? i_speed_limit : lin_full[POS_W-1:0];

    always_comb begin
        n_lin = '0;
        n_ang = '0;
        if (r_dist > DIST_MIN) begin
            if (r_mag > ANGLE_MIN) begin
                n_ang = r_mag[HD_W-1:0];
            end else begin
                n_lin = lin_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_lin <= n_lin;
            r_ang <= n_ang;
        end
    end

    assign o_valid         = r_b_valid;
    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;
    assign o_stg_valid     = {r_b_valid, r_a_valid};

endmodule

`default_nettype wire

>>> hw/rtl/go_to_goal_steering.sv
// Channel   Direction  Handshake               Payload
// pose      in         i_in_valid / o_in_stall   i_pos_x, i_pos_y, i_heading
// command   out        o_out_valid / i_out_stall o_linear_speed, o_angular_speed
// config    in         i_cfg_we (no wait)        i_cfg_idx, i_cfg_data
//
// Throughput: one request per cycle while the command side does not stall; the stages are the
// input register, one cell per CORDIC iteration, the length/error stage and the output stage.
// Reset (synchronous, i_rst_n low) empties every stage and loads the register defaults.
// A stall on the command side holds the output register; stages behind it keep
// filling bubbles, and o_in_stall rises only once every stage holds a request.
`default_nettype none

module go_to_goal_steering import gtg_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // pose in
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [POS_W-1:0]       i_pos_x,
    input  wire logic [POS_W-1:0]       i_pos_y,
    input  wire logic signed [HD_W-1:0] i_heading,
    // command out
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [POS_W-1:0]            o_linear_speed,
    output logic [HD_W-1:0]             o_angular_speed,
    // configuration writes
    input  wire logic                   i_cfg_we,
    input  wire logic [IDX_W-1:0]       i_cfg_idx,
    input  wire logic [POS_W-1:0]       i_cfg_data
);

    logic [POS_W-1:0] r_goal_x;
    logic [POS_W-1:0] r_goal_y;
    logic [POS_W-1:0] r_gain;
    logic [POS_W-1:0] r_speed_limit;
    logic             goal_ok;

    // Goal writes outside the open range (0, 12.0) are dropped.
    assign goal_ok = (i_cfg_data != '0) && (i_cfg_data <= GOAL_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x      <= 16'd4096;
            r_goal_y      <= 16'd4096;
            r_gain        <= 16'd4096;
            r_speed_limit <= 16'd12288;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GOAL_X: begin
                    if (goal_ok) r_goal_x <= i_cfg_data;
                end
                CFG_GOAL_Y: begin
                    if (goal_ok) r_goal_y <= i_cfg_data;
                end
                CFG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                CFG_SPEED_LIMIT: begin
                    r_speed_limit <= i_cfg_data;
                end
            endcase
        end
    end

    // vec[k] / stg_vld[k]: output of stage k (0 = input register, k = cell k-1)
    // stg_rdy[k]: the consumer of vec[k] can take it this cycle
    t_vec                   vec [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0] stg_vld;
    logic [CORDIC_STAGES:0] stg_rdy;
    logic                   prep_ready;
    logic [1:0]             post_vld;

    gtg_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (prep_ready),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_heading (i_heading),
        .i_goal_x  (r_goal_x),
        .i_goal_y  (r_goal_y),
        .o_valid   (stg_vld[0]),
        .i_ready   (stg_rdy[0]),
        .o_vec     (vec[0])
    );

    assign o_in_stall = !prep_ready;

    // CORDIC vectoring chain: each cell does one shift-add rotation
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        gtg_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_vld[g]),
            .o_ready (stg_rdy[g]),
            .i_vec   (vec[g]),
            .o_valid (stg_vld[g+1]),
            .i_ready (stg_rdy[g+1]),
            .o_vec   (vec[g+1])
        );
    end

    gtg_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (stg_vld[CORDIC_STAGES]),
        .o_ready         (stg_rdy[CORDIC_STAGES]),
        .i_vec           (vec[CORDIC_STAGES]),
        .i_gain          (r_gain),
        .i_speed_limit   (r_speed_limit),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_stg_valid     (post_vld)
    );

    // Turning and driving never both command motion
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_linear_speed == '0 || o_angular_speed == '0))
        else $error("both speeds nonzero");

    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_angular_speed != '0) |-> (MAG_W'(o_angular_speed) > ANGLE_MIN))
        else $error("turn command below threshold");

    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_linear_speed <= r_speed_limit))
        else $error("linear speed above limit");

    a_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_goal_x != '0) && (r_goal_x <= GOAL_MAX) && (r_goal_y != '0) && (r_goal_y <= GOAL_MAX))
        else $error("goal register out of range");

    // Input stalls only when the whole pipe is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&stg_vld) && (&post_vld) && i_out_stall))
        else $error("input stalled with a bubble in the pipe");

endmodule

`default_nettype wire
